// ===== design/scba_pkg.sv =====
// Shared types, widths and codes for the size-class block allocator.
`default_nettype none

package scba_pkg;

  // Field widths of the request and response transactions
  localparam int unsigned HANDLE_W = 8;
  localparam int unsigned SIZE_W   = 11;
  localparam int unsigned CLASS_W  = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 9;

  // Defaults for the top-level parameters
  localparam int unsigned NUM_BLOCKS_DEF  = 256;
  localparam int unsigned NUM_CLASSES_DEF = 10;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_RANGE      = 2'd1,
    ST_EXHAUSTED  = 2'd2,
    ST_BAD_HANDLE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_op_e;

  typedef struct packed {
    kind_e               kind;
    logic [SIZE_W-1:0]   request_size;
    logic [HANDLE_W-1:0] block_handle;
  } req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] granted_handle;
    logic [CLASS_W-1:0]  size_class;
    status_e             status;
    logic [COUNT_W-1:0]  class_free_count;
    logic [COUNT_W-1:0]  class_used_count;
  } rsp_t;

  // Update command for the per-class counter file
  typedef struct packed {
    logic               we;
    logic [CLASS_W-1:0] cls;
    cnt_op_e            free_op;
    cnt_op_e            used_op;
  } cnt_cmd_t;

endpackage

`default_nettype wire

// ===== design/scba_class_unit.sv =====
// Size-to-class mapping and oversize check.
`default_nettype none

module scba_class_unit #(
  parameter int unsigned NUM_CLASSES = scba_pkg::NUM_CLASSES_DEF
) (
  input  logic [scba_pkg::SIZE_W-1:0]  size_i,
  output logic [scba_pkg::CLASS_W-1:0] cls_o,
  output logic                         oversize_o
);
  import scba_pkg::*;

  // Smallest class whose block of 2^(c+1) bytes covers the size; the
  // compares are monotone, so the last one that holds gives the class.
  always_comb begin
    cls_o = '0;
    for (int i = 0; i < int'(NUM_CLASSES) - 1; i++) begin
      if ((32'd1 << (i + 1)) < 32'(size_i)) begin
        cls_o = CLASS_W'(i + 1);
      end
    end
  end

  assign oversize_o = (32'(size_i) > (32'd1 << NUM_CLASSES));

endmodule

`default_nettype wire

// ===== design/scba_count_unit.sv =====
// Per-class free and used counters; all classes share one write port and one increment/decrement unit per counter kind.
`default_nettype none

module scba_count_unit #(
  parameter int unsigned NUM_BLOCKS  = scba_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned NUM_CLASSES = scba_pkg::NUM_CLASSES_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic [scba_pkg::CLASS_W-1:0]              rd_cls_i,
  output logic [$clog2(NUM_BLOCKS+1)-1:0]           free_o,
  output logic [$clog2(NUM_BLOCKS+1)-1:0]           used_o,
  input  scba_pkg::cnt_cmd_t                        cmd_i
);
  import scba_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned IDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  logic [CNT_W-1:0] free_q [NUM_CLASSES];
  logic [CNT_W-1:0] used_q [NUM_CLASSES];
  logic [CNT_W-1:0] free_cur, used_cur, free_d, used_d;
  logic [IDX_W-1:0] wr_idx;

  assign free_o = free_q[rd_cls_i[IDX_W-1:0]];
  assign used_o = used_q[rd_cls_i[IDX_W-1:0]];

  assign wr_idx   = cmd_i.cls[IDX_W-1:0];
  assign free_cur = free_q[wr_idx];
  assign used_cur = used_q[wr_idx];

  always_comb begin
    case (cmd_i.free_op)
      CNT_INC: free_d = free_cur + CNT_W'(1);
      CNT_DEC: free_d = free_cur - CNT_W'(1);
      default: free_d = free_cur;
    endcase
    case (cmd_i.used_op)
      CNT_INC: used_d = used_cur + CNT_W'(1);
      CNT_DEC: used_d = used_cur - CNT_W'(1);
      default: used_d = used_cur;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(NUM_CLASSES); i++) begin
        free_q[i] <= '0;
        used_q[i] <= '0;
      end
    end else if (cmd_i.we) begin
      free_q[wr_idx] <= free_d;
      used_q[wr_idx] <= used_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/scba_ram.sv =====
// Single-port-write, registered-read RAM.
`default_nettype none

module scba_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/size_class_block_allocator_core.sv =====
// Top level of the size-class block allocator: sequencer, stores and output register.
`default_nettype none

// Allocates and frees fixed blocks in NUM_CLASSES power-of-two size classes
// (2 bytes up to 2^NUM_CLASSES bytes). An allocate transaction pops the most
// recently freed block of its class, or else issues a fresh handle from a bump
// counter and records its class in the tag store; a free transaction looks the
// class up in the tag store and pushes the handle onto that class's stack.
// Every request transaction gives exactly one response transaction. Requests
// are handled one at a time: in_ready_o is high only when the sequencer is
// idle. An allocate goes through the lookup step, then the registered read of
// the stack memory; a free of an issued handle adds a tag step for the tag
// store read before the stack write, and a free of a never-issued handle is
// rejected in the lookup step. A response that is not taken holds the
// sequencer in its final step until the output register frees. No clearing
// pass is needed after reset: the per-class counters reset to zero and bound
// every store access.

module size_class_block_allocator_core #(
  parameter int unsigned NUM_BLOCKS  = scba_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned NUM_CLASSES = scba_pkg::NUM_CLASSES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  scba_pkg::req_t  in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output scba_pkg::rsp_t  out_o
);
  import scba_pkg::*;

  localparam int unsigned BLK_W     = $clog2(NUM_BLOCKS);
  localparam int unsigned CNT_W     = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned STK_DEPTH = NUM_CLASSES * NUM_BLOCKS;
  localparam int unsigned STK_AW    = $clog2(STK_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_TAG,
    S_EMIT
  } state_e;

  state_e              state_q;
  req_t                req_q;
  logic [CLASS_W-1:0]  cls_q;
  status_e             status_q;
  logic [HANDLE_W-1:0] handle_q;
  logic                from_ram_q;
  logic                zero_cnt_q;
  logic [CNT_W-1:0]    next_q;
  rsp_t                out_q;
  logic                out_valid_q;

  // Class unit
  logic [CLASS_W-1:0] size_cls;
  logic               oversize;

  // Counter file
  logic [CLASS_W-1:0] rd_cls;
  logic [CNT_W-1:0]   free_cnt, used_cnt;
  cnt_cmd_t           cnt_cmd;

  // Stores
  logic                stk_we, stk_re;
  logic [STK_AW-1:0]   stk_waddr, stk_raddr;
  logic [HANDLE_W-1:0] stk_rdata;
  logic                tag_we, tag_re;
  logic [BLK_W-1:0]    tag_waddr, tag_raddr;
  logic [CLASS_W-1:0]  tag_rdata;

  // Decisions of the lookup and tag steps
  logic look_range, look_pop, look_fresh, look_exh, look_bad, look_tag;
  logic tag_bad, tag_push;
  logic can_emit, in_accept;

  scba_class_unit #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_class (
    .size_i     (req_q.request_size),
    .cls_o      (size_cls),
    .oversize_o (oversize)
  );

  scba_count_unit #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_count (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_cls_i (rd_cls),
    .free_o   (free_cnt),
    .used_o   (used_cnt),
    .cmd_i    (cnt_cmd)
  );

  // Per-class stacks, one region of NUM_BLOCKS entries per class
  scba_ram #(
    .DEPTH (STK_DEPTH),
    .WIDTH (HANDLE_W)
  ) u_stack_mem (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (req_q.block_handle),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Class of every issued handle
  scba_ram #(
    .DEPTH (NUM_BLOCKS),
    .WIDTH (CLASS_W)
  ) u_tag_mem (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (size_cls),
    .re_i    (tag_re),
    .raddr_i (tag_raddr),
    .rdata_o (tag_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign can_emit   = !out_valid_q || out_ready_i;

  // Read the counters of the class that the current step works on
  always_comb begin
    case (state_q)
      S_LOOK:  rd_cls = size_cls;
      S_TAG:   rd_cls = tag_rdata;
      default: rd_cls = cls_q;
    endcase
  end

  always_comb begin
    look_range = 1'b0;
    look_pop   = 1'b0;
    look_fresh = 1'b0;
    look_exh   = 1'b0;
    look_bad   = 1'b0;
    look_tag   = 1'b0;
    tag_bad    = 1'b0;
    tag_push   = 1'b0;
    if (state_q == S_LOOK) begin
      if (req_q.kind == KIND_ALLOC) begin
        if (oversize) begin
          look_range = 1'b1;
        end else if (free_cnt != '0) begin
          look_pop = 1'b1;
        end else if (32'(next_q) < NUM_BLOCKS) begin
          look_fresh = 1'b1;
        end else begin
          look_exh = 1'b1;
        end
      end else begin
        // Handles at or above the bump counter were never issued
        if (32'(req_q.block_handle) >= 32'(next_q)) begin
          look_bad = 1'b1;
        end else begin
          look_tag = 1'b1;
        end
      end
    end
    if (state_q == S_TAG) begin
      // Drop frees of a class with nothing outstanding (e.g. a double free) or with a full stack
      if (used_cnt == '0 || 32'(free_cnt) >= NUM_BLOCKS) begin
        tag_bad = 1'b1;
      end else begin
        tag_push = 1'b1;
      end
    end
  end

  // Store and counter controls
  always_comb begin
    stk_re    = look_pop;
    stk_raddr = STK_AW'(32'(size_cls) * NUM_BLOCKS
                        + 32'(BLK_W'(free_cnt - CNT_W'(1))));
    stk_we    = tag_push;
    stk_waddr = STK_AW'(32'(tag_rdata) * NUM_BLOCKS + 32'(BLK_W'(free_cnt)));
    tag_we    = look_fresh;
    tag_waddr = BLK_W'(next_q);
    tag_re    = look_tag;
    tag_raddr = BLK_W'(req_q.block_handle);

    cnt_cmd         = '0;
    cnt_cmd.free_op = CNT_HOLD;
    cnt_cmd.used_op = CNT_HOLD;
    if (look_pop) begin
      cnt_cmd.we      = 1'b1;
      cnt_cmd.cls     = size_cls;
      cnt_cmd.free_op = CNT_DEC;
      cnt_cmd.used_op = CNT_INC;
    end else if (look_fresh) begin
      cnt_cmd.we      = 1'b1;
      cnt_cmd.cls     = size_cls;
      cnt_cmd.used_op = CNT_INC;
    end else if (tag_push) begin
      cnt_cmd.we      = 1'b1;
      cnt_cmd.cls     = tag_rdata;
      cnt_cmd.free_op = CNT_INC;
      cnt_cmd.used_op = CNT_DEC;
    end
  end

  // Sequencer, bump counter and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      next_q      <= '0;
      out_valid_q <= 1'b0;
      req_q       <= '0;
      cls_q       <= '0;
      status_q    <= ST_OK;
      handle_q    <= '0;
      from_ram_q  <= 1'b0;
      zero_cnt_q  <= 1'b0;
      out_q       <= '0;
    end else begin
      // Load a new response, or drop the current one once it is taken
      if (state_q == S_EMIT && can_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            req_q   <= in_i;
            state_q <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (look_range) begin
            status_q   <= ST_RANGE;
            cls_q      <= '0;
            handle_q   <= '0;
            from_ram_q <= 1'b0;
            zero_cnt_q <= 1'b1;
            state_q    <= S_EMIT;
          end else if (look_pop) begin
            status_q   <= ST_OK;
            cls_q      <= size_cls;
            handle_q   <= '0;
            from_ram_q <= 1'b1;
            zero_cnt_q <= 1'b0;
            state_q    <= S_EMIT;
          end else if (look_fresh) begin
            status_q   <= ST_OK;
            cls_q      <= size_cls;
            handle_q   <= HANDLE_W'(next_q);
            next_q     <= next_q + CNT_W'(1);
            from_ram_q <= 1'b0;
            zero_cnt_q <= 1'b0;
            state_q    <= S_EMIT;
          end else if (look_exh) begin
            status_q   <= ST_EXHAUSTED;
            cls_q      <= size_cls;
            handle_q   <= '0;
            from_ram_q <= 1'b0;
            zero_cnt_q <= 1'b0;
            state_q    <= S_EMIT;
          end else if (look_bad) begin
            status_q   <= ST_BAD_HANDLE;
            cls_q      <= '0;
            handle_q   <= req_q.block_handle;
            from_ram_q <= 1'b0;
            zero_cnt_q <= 1'b1;
            state_q    <= S_EMIT;
          end else begin
            // Wait for the registered tag store read
            from_ram_q <= 1'b0;
            zero_cnt_q <= 1'b0;
            state_q    <= S_TAG;
          end
        end
        S_TAG: begin
          handle_q <= req_q.block_handle;
          state_q  <= S_EMIT;
          if (tag_bad) begin
            status_q   <= ST_BAD_HANDLE;
            cls_q      <= '0;
            zero_cnt_q <= 1'b1;
          end else begin
            status_q <= ST_OK;
            cls_q    <= tag_rdata;
          end
        end
        S_EMIT: begin
          // Hold until the output register is free
          if (can_emit) begin
            out_q.granted_handle   <= from_ram_q ? stk_rdata : handle_q;
            out_q.size_class       <= cls_q;
            out_q.status           <= status_q;
            out_q.class_free_count <= zero_cnt_q ? '0 : COUNT_W'(free_cnt);
            out_q.class_used_count <= zero_cnt_q ? '0 : COUNT_W'(used_cnt);
            state_q                <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // The bump counter never runs past the pool
  a_next_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(next_q) <= NUM_BLOCKS)
    else $error("bump counter beyond pool size");

  // A successful response only names a handle that has been issued
  a_ok_handle_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_OK) |-> (32'(out_q.granted_handle) < 32'(next_q)))
    else $error("granted handle never issued");

  // Counters change only in the lookup and tag steps
  a_cnt_update_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_cmd.we |-> (state_q == S_LOOK || state_q == S_TAG))
    else $error("counter update outside lookup or tag step");

  // A push stays inside its class's stack region
  a_push_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_we |-> (32'(free_cnt) < NUM_BLOCKS && used_cnt != '0))
    else $error("stack push beyond class region");

  // A response is loaded only when the previous one has been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_valid_q && !out_ready_i) |=> (state_q == S_EMIT))
    else $error("response register overwritten");

endmodule

`default_nettype wire

// ===== sim/scba_checker.sv =====
// Response checker for the size-class block allocator: predicts and compares every transaction.
`timescale 1ns / 1ps

module scba_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  logic            req_ready_i,
  input  scba_pkg::req_t  req_i,
  input  logic            rsp_valid_i,
  input  logic            rsp_ready_i,
  input  scba_pkg::rsp_t  rsp_i,
  output int              mismatch_count_o,
  output int              pending_o
);

  import scba_pkg::*;

  localparam int unsigned NUM_BLOCKS  = NUM_BLOCKS_DEF;
  localparam int unsigned NUM_CLASSES = NUM_CLASSES_DEF;
  localparam int unsigned SIZE_LIMIT  = 1 << NUM_CLASSES;

  // Shadow of the allocator state
  logic [HANDLE_W-1:0] class_stack [NUM_CLASSES][NUM_BLOCKS];
  logic [COUNT_W-1:0]  free_depth  [NUM_CLASSES];
  logic [COUNT_W-1:0]  used_depth  [NUM_CLASSES];
  logic [CLASS_W-1:0]  block_tag   [NUM_BLOCKS];
  logic [COUNT_W-1:0]  next_fresh;

  rsp_t expected_rsp_q[$];
  rsp_t oldest_rsp;
  int   mismatches;

  // Smallest class whose block of 2^(c+1) bytes covers the size
  function automatic logic [CLASS_W-1:0] size_to_class(logic [SIZE_W-1:0] sz);
    int unsigned c;
    c = 0;
    while (c + 1 < NUM_CLASSES && (1 << (c + 1)) < sz) c++;
    return c[CLASS_W-1:0];
  endfunction

  // Apply one request to the shadow state and return the response it causes
  function automatic rsp_t predict_response(req_t r);
    rsp_t                p;
    logic [CLASS_W-1:0]  c;
    logic [HANDLE_W-1:0] h;
    p = '0;
    if (r.kind == KIND_ALLOC) begin
      if (r.request_size > SIZE_LIMIT) begin
        p.status = ST_RANGE;
      end else begin
        c = size_to_class(r.request_size);
        p.size_class = c;
        if (free_depth[c] != 0) begin
          free_depth[c] = free_depth[c] - 1'b1;
          h = class_stack[c][free_depth[c] % NUM_BLOCKS];
        end else if (next_fresh < NUM_BLOCKS) begin
          h = next_fresh[HANDLE_W-1:0];
          block_tag[h] = c;
          next_fresh = next_fresh + 1'b1;
        end else begin
          p.status           = ST_EXHAUSTED;
          p.class_free_count = free_depth[c];
          p.class_used_count = used_depth[c];
          return p;
        end
        used_depth[c]      = used_depth[c] + 1'b1;
        p.status           = ST_OK;
        p.granted_handle   = h;
        p.class_free_count = free_depth[c];
        p.class_used_count = used_depth[c];
      end
    end else begin
      p.granted_handle = r.block_handle;
      p.status         = ST_BAD_HANDLE;
      if (r.block_handle < next_fresh) begin
        c = block_tag[r.block_handle];
        if (used_depth[c] != 0 && free_depth[c] < NUM_BLOCKS) begin
          used_depth[c]                  = used_depth[c] - 1'b1;
          class_stack[c][free_depth[c]] = r.block_handle;
          free_depth[c]                  = free_depth[c] + 1'b1;
          p.status           = ST_OK;
          p.size_class       = c;
          p.class_free_count = free_depth[c];
          p.class_used_count = used_depth[c];
        end
      end
    end
    return p;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        free_depth[c] = '0;
        used_depth[c] = '0;
      end
      next_fresh = '0;
      expected_rsp_q.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      if (req_valid_i && req_ready_i) expected_rsp_q.push_back(predict_response(req_i));
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          mismatches++;
          $display("%0t ns: response transaction with none expected, got handle %0d status %0d",
                   $time, rsp_i.granted_handle, rsp_i.status);
        end else begin
          oldest_rsp = expected_rsp_q.pop_front();
          check_field("granted_handle", oldest_rsp.granted_handle, rsp_i.granted_handle);
          check_field("size_class", oldest_rsp.size_class, rsp_i.size_class);
          check_field("status", oldest_rsp.status, rsp_i.status);
          check_field("class_free_count", oldest_rsp.class_free_count, rsp_i.class_free_count);
          check_field("class_used_count", oldest_rsp.class_used_count, rsp_i.class_used_count);
        end
      end
      mismatch_count_o <= mismatches;
      pending_o        <= expected_rsp_q.size();
    end
  end

endmodule

// ===== sim/tb_size_class_block_allocator_core.sv =====
// Testbench top for the size-class block allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_size_class_block_allocator_core;

  import scba_pkg::*;

  localparam int PERIOD_NS    = 20;
  localparam int DRAIN_CYCLES = 10;   // margin after the last pending response
  localparam int MAX_GAP      = 5;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  req_t in_req;
  logic out_valid;
  logic out_ready;
  rsp_t out_rsp;

  int mismatches;
  int pending;

  // Handles that are believed to be handed out, used to build legal frees
  logic [HANDLE_W-1:0] live_handles[$];
  // Kind of every accepted request still waiting for its response
  kind_e               sent_kinds[$];
  kind_e               done_kind;

  int  allocs_sent, frees_sent, responses_seen;
  int  exhausted_seen, oversize_seen, bad_handle_seen;
  bit  quiet_send, quiet_recv;

  size_class_block_allocator_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_rsp)
  );

  scba_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .req_valid_i      (in_valid),
    .req_ready_i      (in_ready),
    .req_i            (in_req),
    .rsp_valid_i      (out_valid),
    .rsp_ready_i      (out_ready),
    .rsp_i            (out_rsp),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial clk = 1'b0;
  always #(PERIOD_NS / 2) clk = ~clk;

  // Track what comes back so that later frees name handles that are really out.
  // Push the kind first: a response at the same edge always belongs to an older request.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sent_kinds.push_back(in_req.kind);
      if (out_valid && out_ready && sent_kinds.size() != 0) begin
        done_kind = sent_kinds.pop_front();
        responses_seen++;
        case (out_rsp.status)
          ST_EXHAUSTED:  exhausted_seen++;
          ST_RANGE:      oversize_seen++;
          ST_BAD_HANDLE: bad_handle_seen++;
          default: begin
            if (done_kind == KIND_ALLOC) live_handles.push_back(out_rsp.granted_handle);
          end
        endcase
      end
    end
  end

  // Drive one request transaction: idle for a random gap, then hold valid and
  // payload steady until the block takes it.
  task automatic send_request(kind_e k, logic [SIZE_W-1:0] sz, logic [HANDLE_W-1:0] h);
    int gap;
    gap = quiet_send ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req.kind         = k;
    in_req.request_size = sz;
    in_req.block_handle = h;
    in_valid            = 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
    if (k == KIND_ALLOC) allocs_sent++;
    else                 frees_sent++;
    // Flip now and then between gapped and back-to-back stretches
    if ($urandom_range(0, 39) == 0) quiet_send = ~quiet_send;
  endtask

  // Allocate a size drawn so that every class is equally likely
  task automatic alloc_any_class();
    int unsigned cls;
    logic [SIZE_W-1:0] sz;
    cls = $urandom_range(0, NUM_CLASSES_DEF - 1);
    if (cls == 0) sz = SIZE_W'($urandom_range(0, 2));
    else          sz = SIZE_W'($urandom_range((1 << cls) + 1, 1 << (cls + 1)));
    send_request(KIND_ALLOC, sz, HANDLE_W'($urandom_range(0, 255)));
  endtask

  // One random transaction: mostly well-formed allocates and frees of live
  // handles, with a share of noise (oversize, arbitrary handles, raw sizes).
  task automatic random_request(int alloc_pct, int noise_pct);
    int unsigned roll;
    int unsigned idx;
    logic [HANDLE_W-1:0] h;
    roll = $urandom_range(0, 99);
    if (roll < noise_pct) begin
      case ($urandom_range(0, 2))
        0:       send_request(KIND_ALLOC, SIZE_W'($urandom_range(1025, 2047)),
                              HANDLE_W'($urandom_range(0, 255)));
        1:       send_request(KIND_FREE, SIZE_W'($urandom_range(0, 2047)),
                              HANDLE_W'($urandom_range(0, 255)));
        default: send_request(KIND_ALLOC, SIZE_W'($urandom_range(0, 2047)),
                              HANDLE_W'($urandom_range(0, 255)));
      endcase
    end else if (roll < noise_pct + alloc_pct || live_handles.size() == 0) begin
      alloc_any_class();
    end else begin
      idx = $urandom_range(0, live_handles.size() - 1);
      h   = live_handles[idx];
      live_handles.delete(idx);
      send_request(KIND_FREE, SIZE_W'($urandom_range(0, 2047)), h);
    end
  endtask

  // Response side: stall a random number of cycles before each response,
  // with stretches of permanent readiness.
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      stall = quiet_recv ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
      if ($urandom_range(0, 29) == 0) quiet_recv = ~quiet_recv;
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_req   = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed: tiny sizes, class boundaries, oversize, LIFO reuse,
    // double free, never-issued handles, ignored fields
    send_request(KIND_ALLOC, 11'd0, 8'h00);      // tiny sizes all land in class 0
    send_request(KIND_ALLOC, 11'd1, 8'h00);
    send_request(KIND_ALLOC, 11'd2, 8'h00);
    send_request(KIND_ALLOC, 11'd3, 8'h00);
    send_request(KIND_ALLOC, 11'd4, 8'hFF);      // handle field ignored on allocate
    send_request(KIND_ALLOC, 11'd5, 8'h00);
    send_request(KIND_ALLOC, 11'd1024, 8'h00);   // largest class exactly
    send_request(KIND_ALLOC, 11'd1025, 8'h00);   // just over the top
    send_request(KIND_ALLOC, 11'd2047, 8'hAA);   // largest size field
    send_request(KIND_ALLOC, 11'd513, 8'h00);
    send_request(KIND_ALLOC, 11'd512, 8'h00);
    send_request(KIND_FREE, 11'd2047, 8'd1);     // size field ignored on free
    send_request(KIND_FREE, 11'd0, 8'd0);
    send_request(KIND_ALLOC, 11'd2, 8'h00);      // pops the most recent free
    send_request(KIND_FREE, 11'd0, 8'd0);
    send_request(KIND_FREE, 11'd0, 8'd6);
    send_request(KIND_FREE, 11'd0, 8'd7);
    send_request(KIND_FREE, 11'd0, 8'd7);        // double free with class drained
    send_request(KIND_FREE, 11'd0, 8'd255);      // never issued
    send_request(KIND_FREE, 11'd0, 8'd9);        // first handle not yet issued
    send_request(KIND_ALLOC, 11'd1000, 8'h00);
    send_request(KIND_ALLOC, 11'd33, 8'h00);
    send_request(KIND_FREE, 11'd0, 8'd8);
    send_request(KIND_FREE, 11'd0, 8'd2);

    // Random: a churn phase, an allocate-heavy phase that drains the pool,
    // then churn again once the bump counter is spent
    repeat (120) random_request(60, 10);
    repeat (230) random_request(95, 3);
    repeat (80)  random_request(45, 10);

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("ran %0d allocate and %0d free requests, %0d responses checked",
             allocs_sent, frees_sent, responses_seen);
    $display("outcomes seen: %0d pool exhausted, %0d oversize, %0d bad handle",
             exhausted_seen, oversize_seen, bad_handle_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
